>>> hdl/sitt_pkg.sv
// shared types and constants for sequence idle time insertion
// job record, breakpoint entry and breakpoint list command/response structs
package sitt_pkg;

    localparam int MAX_JOBS = 32;
    localparam int JOB_AW   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int BP_CAP   = MAX_JOBS + 1;
    localparam int BP_AW    = $clog2(BP_CAP);
    localparam int BP_DEPTH = 1 << BP_AW;
    localparam int BP_CW    = $clog2(BP_CAP + 1);

    typedef struct packed {
        logic [4:0]         id;
        logic signed [31:0] due;
        logic signed [31:0] earl;
        logic signed [31:0] late;
        logic [15:0]        ew;
        logic [15:0]        tw;
        logic [15:0]        dur;
        logic signed [31:0] start;
    } t_job;

    typedef struct packed {
        logic signed [31:0] moment;
        logic signed [31:0] cost;
    } t_bp;

    typedef enum logic [2:0] {
        BP_NONE   = 3'd0,
        BP_CLEAR  = 3'd1,
        BP_SHIFT  = 3'd2,
        BP_INSERT = 3'd3,
        BP_SCAN   = 3'd4
    } t_bp_op;

    typedef struct packed {
        t_bp_op             op;
        logic signed [31:0] moment;
        logic signed [31:0] cost;
        logic signed [31:0] lim;
        logic signed [31:0] orig;
    } t_bp_cmd;

    typedef struct packed {
        logic               done;
        logic signed [31:0] fin;
        logic signed [31:0] g;
    } t_bp_rsp;

endpackage

>>> hdl/sitt_bp_list.sv
// sorted cost breakpoint list kept in a circular synchronous memory
// depends on sitt_pkg; performs clear, offset shift, insert and gather scan
module sitt_bp_list import sitt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_bp_cmd i_cmd,
    output t_bp_rsp o_rsp
);

    typedef enum logic [4:0] {
        B_IDLE    = 5'b00001,
        B_INS_RD  = 5'b00010,
        B_INS_WR  = 5'b00100,
        B_SCAN_RD = 5'b01000,
        B_SCAN_EV = 5'b10000
    } t_bstate;

    t_bp                r_bp_mem [BP_DEPTH];
    t_bp                r_rd;
    t_bstate            r_state, n_state;
    logic [BP_CW-1:0]   r_count, n_count;
    logic [BP_AW-1:0]   r_head, n_head;
    logic [BP_CW-1:0]   r_j, n_j;
    logic signed [31:0] r_offset, n_offset;
    logic signed [31:0] r_key, n_key;
    logic signed [31:0] r_cost, n_cost;
    logic signed [31:0] r_lim, n_lim;
    logic signed [31:0] r_orig, n_orig;
    logic signed [31:0] r_g, n_g;
    logic signed [31:0] r_fin, n_fin;
    logic               r_done, n_done;

    logic               we, re;
    logic [BP_AW-1:0]   waddr, raddr;
    t_bp                wdata;

    always_comb begin
        logic signed [31:0] push;
        logic signed [31:0] gn;
        n_state  = r_state;
        n_count  = r_count;
        n_head   = r_head;
        n_j      = r_j;
        n_offset = r_offset;
        n_key    = r_key;
        n_cost   = r_cost;
        n_lim    = r_lim;
        n_orig   = r_orig;
        n_g      = r_g;
        n_fin    = r_fin;
        n_done   = 1'b0;
        we       = 1'b0;
        re       = 1'b0;
        waddr    = r_head + r_j[BP_AW-1:0];
        raddr    = r_head + r_j[BP_AW-1:0];
        wdata    = '{moment: r_key, cost: r_cost};
        push     = r_rd.moment + r_offset;
        gn       = r_g + r_rd.cost;
        case (r_state)
            B_IDLE: begin
                case (i_cmd.op)
                    BP_CLEAR: begin
                        n_count  = '0;
                        n_head   = '0;
                        n_offset = '0;
                    end
                    BP_SHIFT: begin
                        n_offset = r_offset + i_cmd.moment;
                        n_done   = 1'b1;
                    end
                    BP_INSERT: begin
                        n_key  = i_cmd.moment - r_offset;
                        n_cost = i_cmd.cost;
                        n_j    = r_count;
                        if (r_count == BP_CW'(BP_CAP)) begin
                            n_done = 1'b1;
                        end else begin
                            n_state = B_INS_RD;
                        end
                    end
                    BP_SCAN: begin
                        n_lim   = i_cmd.lim;
                        n_orig  = i_cmd.orig;
                        n_fin   = i_cmd.orig;
                        n_g     = i_cmd.cost;
                        n_j     = '0;
                        n_state = B_SCAN_RD;
                    end
                    default: ;
                endcase
            end
            B_INS_RD: begin
                if (r_j == '0) begin
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                    n_done  = 1'b1;
                    n_state = B_IDLE;
                end else begin
                    re      = 1'b1;
                    raddr   = r_head + r_j[BP_AW-1:0] - 1'b1;
                    n_state = B_INS_WR;
                end
            end
            B_INS_WR: begin
                we = 1'b1;
                if (r_rd.moment > r_key) begin
                    wdata   = r_rd;
                    n_j     = r_j - 1'b1;
                    n_state = B_INS_RD;
                end else begin
                    n_count = r_count + 1'b1;
                    n_done  = 1'b1;
                    n_state = B_IDLE;
                end
            end
            B_SCAN_RD: begin
                if (r_j == r_count) begin
                    n_head  = r_head + r_j[BP_AW-1:0];
                    n_count = '0;
                    n_done  = 1'b1;
                    n_state = B_IDLE;
                end else begin
                    re      = 1'b1;
                    n_state = B_SCAN_EV;
                end
            end
            B_SCAN_EV: begin
                if (r_g > 0 && push > r_lim) begin
                    n_head  = r_head + r_j[BP_AW-1:0];
                    n_count = r_count - r_j;
                    n_done  = 1'b1;
                    n_state = B_IDLE;
                end else begin
                    n_g = gn;
                    if (gn > 0) begin
                        n_fin = r_orig + push;
                    end
                    n_j     = r_j + 1'b1;
                    n_state = B_SCAN_RD;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_bp_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd <= r_bp_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_count  <= '0;
            r_offset <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_offset <= n_offset;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_j    <= n_j;
        r_key  <= n_key;
        r_cost <= n_cost;
        r_lim  <= n_lim;
        r_orig <= n_orig;
        r_g    <= n_g;
        r_fin  <= n_fin;
    end

    assign o_rsp = '{done: r_done, fin: r_fin, g: r_g};

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= BP_CW'(BP_CAP))
        else $error("breakpoint count above capacity");
    a_cmd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op != BP_NONE |-> r_state == B_IDLE)
        else $error("breakpoint command while busy");
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_INS_RD || r_state == B_INS_WR) |-> r_count < BP_CW'(BP_CAP))
        else $error("insert into full breakpoint list");

endmodule

>>> hdl/sequence_idle_time_insertion.sv
// top level of sequence idle time insertion: job store memory and sequencer
// depends on sitt_pkg and sitt_bp_list
//
// input channel: one job per transaction (i_valid / o_stall), in sequence order.
// a transaction with i_last_job set closes the sequence; up to MAX_JOBS jobs are
// buffered, further jobs overwrite the last slot.
// o_stall is low only while idle, so one job is taken per cycle during loading.
// after the closing job a backward pass runs over the jobs, last to first; each
// step reads the job memory and walks the breakpoint memory entry by entry for
// its inserts and, when the job is not late, a gather scan; the list gains at
// most two entries per job processed and holds at most BP_CAP entries.
// a forward pass then emits one result transaction per job in sequence order
// (o_valid / i_stall), reading the next job only after the last result is taken;
// while i_stall is high the result holds and the pass waits.
// reset clears the control state and the buffered count; memory contents are
// only read after they were written in the current sequence.
module sequence_idle_time_insertion import sitt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [4:0]         i_job_id,
    input  logic signed [31:0] i_due_time,
    input  logic signed [31:0] i_earliest_start,
    input  logic signed [31:0] i_latest_start,
    input  logic [15:0]        i_early_weight,
    input  logic [15:0]        i_tardy_weight,
    input  logic [15:0]        i_duration,
    input  logic               i_last_job,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [4:0]         o_out_job_id,
    output logic signed [31:0] o_start_time,
    output logic               o_out_last
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_INIT_RD  = 16'h0002,
        S_INIT_EV  = 16'h0004,
        S_INIT_INS = 16'h0008,
        S_BK_RD    = 16'h0010,
        S_BK_EV    = 16'h0020,
        S_LATE_SH  = 16'h0040,
        S_LATE_INS = 16'h0080,
        S_E_INS    = 16'h0100,
        S_E_SCAN   = 16'h0200,
        S_E_SH     = 16'h0400,
        S_E_INS2   = 16'h0800,
        S_BK_WB    = 16'h1000,
        S_OUT_RD   = 16'h2000,
        S_OUT_EV   = 16'h4000,
        S_OUT_HOLD = 16'h8000
    } t_state;

    t_job               r_job_mem [MAX_JOBS];
    t_job               r_rd;
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_loaded, n_loaded;
    logic [JOB_AW-1:0]  r_last, n_last;
    logic [JOB_AW-1:0]  r_p, n_p;
    logic [JOB_AW-1:0]  r_k, n_k;
    logic signed [31:0] r_start, n_start;
    logic signed [31:0] r_pl, n_pl;
    logic signed [31:0] r_prev, n_prev;
    logic signed [31:0] r_orig, n_orig;
    logic signed [31:0] r_g, n_g;
    t_bp_cmd            r_cmd, n_cmd;
    logic               r_o_valid, n_o_valid;
    logic [4:0]         r_o_id, n_o_id;
    logic signed [31:0] r_o_start, n_o_start;
    logic               r_o_last, n_o_last;
    t_bp_rsp            bp_rsp;

    logic               mem_we, mem_re;
    logic [JOB_AW-1:0]  mem_waddr, mem_raddr;
    t_job               mem_wdata;
    logic [JOB_AW-1:0]  slot;

    assign slot = (r_loaded < CNT_W'(MAX_JOBS)) ? r_loaded[JOB_AW-1:0]
                                                : JOB_AW'(MAX_JOBS - 1);

    sitt_bp_list u_bp_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_cmd),
        .o_rsp   (bp_rsp)
    );

    always_comb begin
        logic signed [31:0] s;
        logic signed [31:0] room;
        logic signed [31:0] pl_min;
        logic signed [31:0] fin;
        logic signed [31:0] mx;
        logic signed [31:0] st;
        n_state   = r_state;
        n_loaded  = r_loaded;
        n_last    = r_last;
        n_p       = r_p;
        n_k       = r_k;
        n_start   = r_start;
        n_pl      = r_pl;
        n_prev    = r_prev;
        n_orig    = r_orig;
        n_g       = r_g;
        n_cmd     = '0;
        n_cmd.op  = BP_NONE;
        n_o_valid = r_o_valid;
        n_o_id    = r_o_id;
        n_o_start = r_o_start;
        n_o_last  = r_o_last;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_p;
        mem_raddr = r_p;
        mem_wdata = r_rd;
        s         = r_prev - $signed({16'b0, r_rd.dur});
        room      = r_rd.late - s;
        pl_min    = (room < r_pl) ? room : r_pl;
        fin       = bp_rsp.fin;
        mx        = r_orig + r_pl;
        st        = r_rd.start;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    mem_we          = 1'b1;
                    mem_waddr       = slot;
                    mem_wdata.id    = i_job_id;
                    mem_wdata.due   = i_due_time;
                    mem_wdata.earl  = i_earliest_start;
                    mem_wdata.late  = i_latest_start;
                    mem_wdata.ew    = i_early_weight;
                    mem_wdata.tw    = i_tardy_weight;
                    mem_wdata.dur   = i_duration;
                    mem_wdata.start = i_due_time;
                    n_loaded        = CNT_W'(slot) + 1'b1;
                    if (i_last_job) begin
                        n_loaded = '0;
                        n_last   = slot;
                        n_state  = S_INIT_RD;
                    end
                end
            end
            S_INIT_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_last;
                n_cmd.op  = BP_CLEAR;
                n_state   = S_INIT_EV;
            end
            S_INIT_EV: begin
                mem_we          = 1'b1;
                mem_waddr       = r_last;
                mem_wdata.start = r_rd.due;
                n_prev          = r_rd.due;
                n_pl            = r_rd.late - r_rd.due;
                n_cmd.op        = BP_INSERT;
                n_cmd.cost      = $signed({16'b0, r_rd.tw});
                n_state         = S_INIT_INS;
            end
            S_INIT_INS: begin
                if (bp_rsp.done) begin
                    if (r_last == '0) begin
                        n_k     = '0;
                        n_state = S_OUT_RD;
                    end else begin
                        n_p     = r_last - 1'b1;
                        n_state = S_BK_RD;
                    end
                end
            end
            S_BK_RD: begin
                mem_re  = 1'b1;
                n_state = S_BK_EV;
            end
            S_BK_EV: begin
                if (s > r_rd.due) begin
                    n_pl         = pl_min + (s - r_rd.due);
                    n_cmd.op     = BP_SHIFT;
                    n_cmd.moment = s - r_rd.due;
                    n_start      = r_rd.due;
                    n_state      = S_LATE_SH;
                end else begin
                    n_pl         = pl_min;
                    n_orig       = s;
                    n_cmd.op     = BP_INSERT;
                    n_cmd.moment = r_rd.due - s;
                    n_cmd.cost   = $signed({15'b0, {1'b0, r_rd.ew} + {1'b0, r_rd.tw}});
                    n_state      = S_E_INS;
                end
            end
            S_LATE_SH: begin
                if (bp_rsp.done) begin
                    n_cmd.op   = BP_INSERT;
                    n_cmd.cost = $signed({16'b0, r_rd.tw});
                    n_state    = S_LATE_INS;
                end
            end
            S_LATE_INS: begin
                if (bp_rsp.done) begin
                    n_state = S_BK_WB;
                end
            end
            S_E_INS: begin
                if (bp_rsp.done) begin
                    n_cmd.op   = BP_SCAN;
                    n_cmd.lim  = r_rd.earl - r_orig;
                    n_cmd.orig = r_orig;
                    n_cmd.cost = -$signed({16'b0, r_rd.ew});
                    n_state    = S_E_SCAN;
                end
            end
            S_E_SCAN: begin
                if (bp_rsp.done) begin
                    if (fin < r_rd.earl) begin
                        fin = r_rd.earl;
                    end
                    if (fin > mx) begin
                        fin = mx;
                    end
                    n_start      = fin;
                    n_pl         = r_pl + (r_orig - fin);
                    n_g          = bp_rsp.g;
                    n_cmd.op     = BP_SHIFT;
                    n_cmd.moment = r_orig - fin;
                    n_state      = S_E_SH;
                end
            end
            S_E_SH: begin
                if (bp_rsp.done) begin
                    n_cmd.op   = BP_INSERT;
                    n_cmd.cost = r_g;
                    n_state    = S_E_INS2;
                end
            end
            S_E_INS2: begin
                if (bp_rsp.done) begin
                    n_state = S_BK_WB;
                end
            end
            S_BK_WB: begin
                mem_we          = 1'b1;
                mem_wdata.start = r_start;
                n_prev          = r_start;
                if (r_p == '0) begin
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_p     = r_p - 1'b1;
                    n_state = S_BK_RD;
                end
            end
            S_OUT_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_k;
                n_state   = S_OUT_EV;
            end
            S_OUT_EV: begin
                if (r_k != '0 && r_prev > st) begin
                    st = r_prev;
                end
                n_o_valid = 1'b1;
                n_o_id    = r_rd.id;
                n_o_start = st;
                n_o_last  = (r_k == r_last);
                n_prev    = st + $signed({16'b0, r_rd.dur});
                n_state   = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (!i_stall) begin
                    n_o_valid = 1'b0;
                    if (r_k == r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_job_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_job_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_loaded  <= '0;
            r_pl      <= '0;
            r_cmd     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_loaded  <= n_loaded;
            r_pl      <= n_pl;
            r_cmd     <= n_cmd;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last    <= n_last;
        r_p       <= n_p;
        r_k       <= n_k;
        r_start   <= n_start;
        r_prev    <= n_prev;
        r_orig    <= n_orig;
        r_g       <= n_g;
        r_o_id    <= n_o_id;
        r_o_start <= n_o_start;
        r_o_last  <= n_o_last;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_out_job_id = r_o_id;
    assign o_start_time = r_o_start;
    assign o_out_last   = r_o_last;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT_HOLD)
        else $error("result valid outside output hold");
    a_loaded_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= CNT_W'(MAX_JOBS))
        else $error("loaded count above capacity");
    a_drop_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> $past(!i_stall))
        else $error("result dropped while stalled");

endmodule
